// ----- rtl/csvs_pkg.sv -----
`default_nettype none

package csvs_pkg;

   localparam int MaxResults = 4;
   localparam int CountWidth = $clog2(MaxResults + 1);
   localparam int IndexWidth = $clog2(MaxResults);

   localparam logic [7:0] ChComma  = 8'h2C;
   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChLf     = 8'h0A;

   typedef enum logic [1:0] {
      MODE_SEEK_QUOTE = 2'd0,
      MODE_FIELD      = 2'd1,
      MODE_SEEK_COMMA = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_END_FIELD = 2'd1,
      KIND_ACCEPT    = 2'd2,
      KIND_REJECT    = 2'd3
   } kind_type;

   typedef struct packed {
      mode_type mode;
      logic     unquoted_field;
      logic     comma_seen_last;
      logic     escape_pending;
      logic     field_has_data;
      logic     line_rejected;
   } parse_state_type;

   localparam parse_state_type StateReset = '{
      mode:            MODE_SEEK_QUOTE,
      unquoted_field:  1'b0,
      comma_seen_last: 1'b0,
      escape_pending:  1'b0,
      field_has_data:  1'b0,
      line_rejected:   1'b0
   };

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } result_type;

   // results caused by one input word, entry 0 goes out first
   typedef struct packed {
      logic [CountWidth-1:0]        count;
      result_type [MaxResults-1:0]  res;
   } bundle_type;

   function automatic bundle_type emit(bundle_type b, kind_type k, logic [7:0] d);
      bundle_type r;
      r = b;
      if (r.count < CountWidth'(MaxResults)) begin
         r.res[r.count[IndexWidth-1:0]].kind = k;
         r.res[r.count[IndexWidth-1:0]].data = d;
         r.count = r.count + CountWidth'(1);
      end
      return r;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/csv_line_field_splitter.sv -----
// csv line field splitter
//
// req channel: one raw byte of a csv line per word, req_tlast high on the
// line's last byte. rsp channel: one result per word, rsp_tuser gives the
// kind (field byte, end of field, line accepted, line rejected), rsp_tdata
// the field byte (zero for other kinds), rsp_tlast marks the last result
// caused by one input byte.
// path: a byte taken into the input register is parsed combinationally and
// its results are loaded into the result register, which drives rsp.
// throughput: one byte per cycle as long as each byte gives at most one
// result and rsp_tready stays high; a byte that gives n results (up to 4)
// holds the result register until all n have left through the single
// result port. bytes that give no result pass without touching the result
// register. a stalled rsp_tready holds the current result; the input
// register keeps its byte and req_tready falls once both registers are
// occupied and the held byte gives a result.
// reset (synchronous) empties both registers and returns the parser to
// the start of a line.

`default_nettype none

module csv_line_field_splitter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] ch
   input  wire logic       req_tlast,   // line_end
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [1:0] kind
   output logic            rsp_tlast    // run_last
);

   logic                                a_valid_ff, a_valid_in;
   logic [7:0]                          a_ch_ff;
   logic                                a_last_ff;
   logic                                b_valid_ff, b_valid_in;
   csvs_pkg::bundle_type                b_bundle_ff;
   logic [csvs_pkg::IndexWidth-1:0]     b_idx_ff, b_idx_in;

   csvs_pkg::bundle_type                step_bundle;
   logic                                req_take;
   logic                                a_consume;
   logic                                b_load;
   logic                                b_last;
   logic                                b_free;

   csvs_step u_step (
      .clock    (clock),
      .reset    (reset),
      .ch       (a_ch_ff),
      .line_end (a_last_ff),
      .advance  (a_consume),
      .bundle   (step_bundle)
   );

   assign b_last = ({1'b0, b_idx_ff} == b_bundle_ff.count - csvs_pkg::CountWidth'(1));
   assign b_free = !b_valid_ff || (rsp_tready && b_last);

   // a byte with no result never waits for the result register
   assign a_consume  = a_valid_ff && ((step_bundle.count == '0) || b_free);
   assign b_load     = a_consume && (step_bundle.count != '0);
   assign req_tready = !a_valid_ff || a_consume;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_take) begin
         a_valid_in = 1'b1;
      end else if (a_consume) begin
         a_valid_in = 1'b0;
      end
      b_valid_in = b_valid_ff;
      b_idx_in   = b_idx_ff;
      if (b_load) begin
         b_valid_in = 1'b1;
         b_idx_in   = '0;
      end else if (b_valid_ff && rsp_tready) begin
         if (b_last) begin
            b_valid_in = 1'b0;
         end else begin
            b_idx_in = b_idx_ff + csvs_pkg::IndexWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         b_idx_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         b_idx_ff   <= b_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         a_ch_ff   <= req_tdata;
         a_last_ff <= req_tlast;
      end
      if (b_load) begin
         b_bundle_ff <= step_bundle;
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tuser  = b_bundle_ff.res[b_idx_ff].kind;
   assign rsp_tdata  = b_bundle_ff.res[b_idx_ff].data;
   assign rsp_tlast  = b_last;

`ifndef SYNTHESIS
   a_result_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_bundle_ff.count != '0))
      else $error("result register holds an empty bundle");

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> ({1'b0, b_idx_ff} < b_bundle_ff.count))
      else $error("result index beyond bundle count");

   a_index_holds_on_stall : assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !rsp_tready) |=> (b_valid_ff && $stable(b_idx_ff)))
      else $error("result index moved while stalled");

   a_input_held : assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !a_consume) |=> (a_valid_ff && $stable(a_ch_ff) && $stable(a_last_ff)))
      else $error("input byte lost before it was parsed");
`endif

endmodule

`default_nettype wire

// ----- rtl/csvs_step.sv -----
`default_nettype none

module csvs_step (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           ch,
   input  wire logic                 line_end,
   input  wire logic                 advance,
   output csvs_pkg::bundle_type      bundle
);

   csvs_pkg::parse_state_type state_ff;
   csvs_pkg::parse_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csvs_pkg::StateReset;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      csvs_pkg::parse_state_type s;
      csvs_pkg::bundle_type      b;
      logic                      do_field;
      logic [7:0]                term;
      s        = state_ff;
      b        = '0;
      do_field = 1'b0;
      term     = csvs_pkg::ChQuote;
      if (!s.line_rejected) begin
         unique case (s.mode)
            csvs_pkg::MODE_FIELD: begin
               s.comma_seen_last = 1'b0;
               if (s.escape_pending) begin
                  s.escape_pending = 1'b0;
                  if (ch == csvs_pkg::ChQuote || ch == csvs_pkg::ChBslash) begin
                     b = csvs_pkg::emit(b, csvs_pkg::KIND_BYTE, ch);
                     s.field_has_data = 1'b1;
                  end else begin
                     // not an escape: the backslash is literal, byte handled as usual
                     b = csvs_pkg::emit(b, csvs_pkg::KIND_BYTE, csvs_pkg::ChBslash);
                     s.field_has_data = 1'b1;
                     do_field = 1'b1;
                  end
               end else begin
                  do_field = 1'b1;
               end
               if (do_field) begin
                  term = s.unquoted_field ? csvs_pkg::ChComma : csvs_pkg::ChQuote;
                  if (ch != term) begin
                     if (ch == csvs_pkg::ChBslash) begin
                        s.escape_pending = 1'b1;
                     end else begin
                        b = csvs_pkg::emit(b, csvs_pkg::KIND_BYTE, ch);
                        s.field_has_data = 1'b1;
                     end
                  end else begin
                     if (s.unquoted_field) begin
                        s.mode = csvs_pkg::MODE_SEEK_QUOTE;
                        s.comma_seen_last = 1'b1;
                     end else begin
                        s.mode = csvs_pkg::MODE_SEEK_COMMA;
                     end
                     b = csvs_pkg::emit(b, csvs_pkg::KIND_END_FIELD, 8'h00);
                     s.field_has_data = 1'b0;
                     s.unquoted_field = 1'b0;
                  end
               end
            end
            csvs_pkg::MODE_SEEK_COMMA: begin
               if (!csvs_pkg::is_space(ch)) begin
                  if (ch == csvs_pkg::ChComma) begin
                     s.mode = csvs_pkg::MODE_SEEK_QUOTE;
                     s.comma_seen_last = 1'b1;
                  end else begin
                     b = csvs_pkg::emit(b, csvs_pkg::KIND_REJECT, 8'h00);
                     s.line_rejected = 1'b1;
                  end
               end
            end
            default: begin
               if (!csvs_pkg::is_space(ch)) begin
                  if (ch == csvs_pkg::ChComma) begin
                     b = csvs_pkg::emit(b, csvs_pkg::KIND_END_FIELD, 8'h00);
                     s.comma_seen_last = 1'b1;
                  end else begin
                     s.comma_seen_last = 1'b0;
                     if (ch != csvs_pkg::ChQuote) begin
                        b = csvs_pkg::emit(b, csvs_pkg::KIND_BYTE, ch);
                        s.field_has_data = 1'b1;
                        s.unquoted_field = 1'b1;
                     end
                     s.mode = csvs_pkg::MODE_FIELD;
                  end
               end
            end
         endcase
         if (line_end && !s.line_rejected) begin
            if (s.escape_pending) begin
               s.escape_pending = 1'b0;
               b = csvs_pkg::emit(b, csvs_pkg::KIND_BYTE, csvs_pkg::ChBslash);
               s.field_has_data = 1'b1;
            end
            if ((s.mode == csvs_pkg::MODE_FIELD && s.field_has_data) || s.comma_seen_last) begin
               b = csvs_pkg::emit(b, csvs_pkg::KIND_END_FIELD, 8'h00);
            end
            b = csvs_pkg::emit(b, csvs_pkg::KIND_ACCEPT, 8'h00);
         end
      end
      if (line_end) begin
         s = csvs_pkg::StateReset;
      end
      state_in = s;
      bundle   = b;
   end

endmodule

`default_nettype wire
